// ----- rtl/ibp_pkg.sv -----
`default_nettype none

package ibp_pkg;

    // Field widths
    localparam int unsigned COUNT_W = 13;   // entry_count register
    localparam int unsigned INDEX_W = 12;   // index_value
    localparam int unsigned BYTE_W  = 8;    // packed_byte
    localparam int unsigned SUM_W   = 16;   // checksum
    localparam int unsigned WIDTH_W = 4;    // bits per entry, 0..13

    // Bits left over between requests, and how many of them are filled
    localparam int unsigned PEND_W  = 7;
    localparam int unsigned FILL_W  = 3;

    // Working window: pending bits plus one shifted entry, in whole bytes
    localparam int unsigned ACC_W   = 24;
    localparam int unsigned TOTAL_W = 5;

    // Results held for one request
    localparam int unsigned SLOTS   = 3;
    localparam int unsigned SLOT_W  = 2;

    // Derived block configuration
    typedef struct packed {
        logic [COUNT_W-1:0] count;   // effective entries per block
        logic [WIDTH_W-1:0] width;   // bits per entry
        logic [INDEX_W-1:0] mask;    // low width bits set
    } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/ibp_cfg.sv -----
`default_nettype none

module ibp_cfg
    import ibp_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 4096
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [COUNT_W-1:0] cfg_wr_data,
    output cfg_t                    cfg
);

    localparam logic [16:0] MAX_LIM = 17'(MAX_ENTRIES);

    cfg_t                cfg_reg;
    cfg_t                cfg_next;
    logic [COUNT_W-1:0]  count_eff;
    logic [COUNT_W-1:0]  count_m1;
    logic [WIDTH_W-1:0]  width_c;
    logic [COUNT_W:0]    mask_wide;

    // Clamp the count and derive the entry width and mask
    always_comb begin
        count_eff = cfg_wr_data;
        if (cfg_wr_data == '0) begin
            count_eff = COUNT_W'(1);
        end else if ({4'b0, cfg_wr_data} > MAX_LIM) begin
            count_eff = COUNT_W'(MAX_LIM);
        end
        count_m1 = count_eff - COUNT_W'(1);
        width_c  = '0;
        for (int i = 0; i < COUNT_W; i++) begin
            if (count_m1[i]) begin
                width_c = WIDTH_W'(i + 1);
            end
        end
        mask_wide = (14'(1) << width_c) - 14'(1);
        cfg_next.count = count_eff;
        cfg_next.width = width_c;
        cfg_next.mask  = mask_wide[INDEX_W-1:0];
    end

    // Hold the configuration until the next write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.count <= COUNT_W'(1);
            cfg_reg.width <= '0;
            cfg_reg.mask  <= '0;
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/index_bit_packer.sv -----
`default_nettype none

// Index bit packer. Each request carries one index in s_tdata[11:0]; it is
// cut to ceil(log2(entry_count)) bits and appended LSB first above the bits
// left from earlier requests. Every full byte comes out as one result with
// the running 16-bit sum of the block's bytes; the entry_count-th request of
// a block flushes the partial byte zero padded and marks its last result
// with m_tlast. An index at or above entry_count is still packed and sets
// range_error on each of its results. A request yields zero to three
// results. Requests are taken one per clock into an input register while
// the result group can accept them; one pass of logic turns each into a
// result group (one or two results for a 12-bit entry, three when it also
// closes a block with a partial byte, about 1.5 on average at full width),
// and results leave one per clock while m_tready is high. A result reaches
// the output through the input register and then the group registers.
// Write entry_count only while the block is idle; 0 acts as 1 and values
// above MAX_ENTRIES are held at MAX_ENTRIES.

module index_bit_packer
    import ibp_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 4096
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration
    input  wire logic               cfg_wr_en,
    input  wire logic [COUNT_W-1:0] cfg_wr_data,   // entry_count
    // index stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [15:0]        s_tdata,       // [11:0] index_value
    // packed stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [23:0]             m_tdata,       // [7:0] packed_byte, [23:8] checksum
    output logic [1:0]              m_tuser,       // [0] byte_valid, [1] range_error
    output logic                    m_tlast        // last
);

    cfg_t cfg;

    ibp_cfg #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // Input register
    logic               in_valid_reg;
    logic [INDEX_W-1:0] in_value_reg;

    // Block state
    logic [PEND_W-1:0]  pend_bits_reg, pend_bits_next;
    logic [FILL_W-1:0]  pend_fill_reg, pend_fill_next;
    logic [COUNT_W-1:0] taken_reg, taken_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;

    // Result group
    logic [SLOT_W-1:0]  grp_count_reg, grp_count_next;
    logic [SLOT_W-1:0]  grp_ptr_reg;
    logic [BYTE_W-1:0]  grp_byte_reg [SLOTS];
    logic [SUM_W-1:0]   grp_sum_reg  [SLOTS];
    logic               grp_bvalid_reg, grp_bvalid_next;
    logic               grp_err_reg, grp_err_next;
    logic               grp_ends_reg, grp_ends_next;

    // Pass logic
    logic [INDEX_W-1:0] val_m;
    logic [ACC_W-1:0]   acc;
    logic [TOTAL_W-1:0] total;
    logic [SLOT_W-1:0]  full;
    logic [COUNT_W-1:0] taken_inc;
    logic               ends;
    logic [SUM_W-1:0]   sum0, sum1, sum2;

    logic out_fire;
    logic slot_last;
    logic grp_free;
    logic consume;

    // Handshake
    assign out_fire  = m_tvalid && m_tready;
    assign slot_last = (grp_ptr_reg == grp_count_reg - SLOT_W'(1));
    assign grp_free  = (grp_count_reg == '0) || (m_tready && slot_last);
    assign consume   = in_valid_reg && grp_free;
    assign s_tready  = !in_valid_reg || grp_free;

    // Append the entry, split off full bytes, update the block state
    always_comb begin
        val_m     = in_value_reg & cfg.mask;
        acc       = (ACC_W'(val_m) << pend_fill_reg) | ACC_W'(pend_bits_reg);
        total     = TOTAL_W'(pend_fill_reg) + TOTAL_W'(cfg.width);
        full      = total[4] ? SLOT_W'(2) : (total[3] ? SLOT_W'(1) : SLOT_W'(0));
        taken_inc = taken_reg + COUNT_W'(1);
        ends      = (taken_inc >= cfg.count);

        sum0 = sum_reg + SUM_W'(acc[7:0]);
        sum1 = sum0 + SUM_W'(acc[15:8]);
        sum2 = sum1 + SUM_W'(acc[23:16]);

        grp_err_next    = ({1'b0, in_value_reg} >= cfg.count);
        grp_ends_next   = ends;
        grp_bvalid_next = (total != '0);

        if (ends) begin
            if (total[2:0] != '0) begin
                grp_count_next = full + SLOT_W'(1);
            end else if (full == '0) begin
                grp_count_next = SLOT_W'(1);
            end else begin
                grp_count_next = full;
            end
            pend_bits_next = '0;
            pend_fill_next = '0;
            taken_next     = '0;
            sum_next       = '0;
        end else begin
            grp_count_next = full;
            case (full)
                SLOT_W'(2): pend_bits_next = acc[22:16];
                SLOT_W'(1): pend_bits_next = acc[14:8];
                default:    pend_bits_next = acc[6:0];
            endcase
            case (full)
                SLOT_W'(2): sum_next = sum1;
                SLOT_W'(1): sum_next = sum0;
                default:    sum_next = sum_reg;
            endcase
            pend_fill_next = total[2:0];
            taken_next     = taken_inc;
        end
    end

    // Advance the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_value_reg <= s_tdata[INDEX_W-1:0];
        end
    end

    // Update block state on each request taken into the group
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits_reg <= '0;
            pend_fill_reg <= '0;
            taken_reg     <= '0;
            sum_reg       <= '0;
        end else if (consume) begin
            pend_bits_reg <= pend_bits_next;
            pend_fill_reg <= pend_fill_next;
            taken_reg     <= taken_next;
            sum_reg       <= sum_next;
        end
    end

    // Load a new group, or step through the current one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_count_reg <= '0;
            grp_ptr_reg   <= '0;
        end else if (consume) begin
            grp_count_reg <= grp_count_next;
            grp_ptr_reg   <= '0;
        end else if (out_fire && slot_last) begin
            grp_count_reg <= '0;
            grp_ptr_reg   <= '0;
        end else if (out_fire) begin
            grp_ptr_reg   <= grp_ptr_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (consume) begin
            grp_byte_reg[0] <= acc[7:0];
            grp_byte_reg[1] <= acc[15:8];
            grp_byte_reg[2] <= acc[23:16];
            grp_sum_reg[0]  <= sum0;
            grp_sum_reg[1]  <= sum1;
            grp_sum_reg[2]  <= sum2;
            grp_bvalid_reg  <= grp_bvalid_next;
            grp_err_reg     <= grp_err_next;
            grp_ends_reg    <= grp_ends_next;
        end
    end

    // Drive the current slot
    assign m_tvalid = (grp_count_reg != '0);
    assign m_tdata  = {grp_sum_reg[grp_ptr_reg], grp_byte_reg[grp_ptr_reg]};
    assign m_tuser  = {grp_err_reg, grp_bvalid_reg};
    assign m_tlast  = grp_ends_reg && slot_last;

endmodule

`default_nettype wire

// ----- sim/index_bit_packer_tb.sv -----
`timescale 1ns / 1ps

module index_bit_packer_tb;
    import ibp_pkg::*;

    localparam int unsigned MAX_ENTRIES   = 4096;
    localparam int unsigned LIMIT_CYCLES  = 400000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned RANDOM_ITEMS  = 350;
    localparam int unsigned IN_RANGE_PCT  = 85;
    localparam int unsigned N_CHOICES     = 20;

    // Idle percentages used by the driver and the receiver across the test phases
    localparam int unsigned LOW_IDLE_PCT  = 14;
    localparam int unsigned HIGH_IDLE_PCT = 72;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              byte_valid;
        logic [SUM_W-1:0]  checksum;
        logic              range_error;
        logic              is_last;
    } packed_result_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic [15:0]        s_tdata     = '0;   // [11:0] index_value
    logic               m_tready    = 1'b0;
    wire                s_tready;
    wire                m_tvalid;
    wire  [23:0]        m_tdata;            // [7:0] packed_byte, [23:8] checksum
    wire  [1:0]         m_tuser;            // [0] byte_valid, [1] range_error
    wire                m_tlast;

    index_bit_packer #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #10 aclk = ~aclk;

    // Pending index requests and the packed bytes they should produce
    logic [INDEX_W-1:0] index_q [$];
    packed_result_t     expected_bytes [$];

    // Packer state as seen by the testbench
    int unsigned        block_len  = 1;
    int unsigned        entry_bits = 0;
    logic [PEND_W-1:0]  pend_bits  = '0;
    logic [FILL_W-1:0]  pend_fill  = '0;
    int unsigned        taken      = 0;
    logic [SUM_W-1:0]   block_sum  = '0;

    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    int unsigned errors    = 0;
    int unsigned results   = 0;
    int unsigned block_ends = 0;
    int unsigned flagged   = 0;
    int unsigned requests  = 0;
    int unsigned settings  = 0;
    int unsigned cycles    = 0;

    // Append one index to the bit stream and queue every byte it completes, plus any closing result of a block
    function automatic void pack_index(input logic [INDEX_W-1:0] idx);
        logic [ACC_W-1:0]   acc;
        logic [INDEX_W-1:0] mask;
        logic [BYTE_W-1:0]  partial;
        int unsigned        total;
        int unsigned        k;
        logic               err;
        packed_result_t     grp [SLOTS];
        mask  = INDEX_W'((1 << entry_bits) - 1);
        err   = (idx >= block_len);
        acc   = ACC_W'(pend_bits) | (ACC_W'(idx & mask) << pend_fill);
        total = pend_fill + entry_bits;
        taken++;
        k = 0;
        // emit every full byte
        while (total >= 8) begin
            block_sum = block_sum + SUM_W'(acc[7:0]);
            grp[k] = '{acc[7:0], 1'b1, block_sum, err, 1'b0};
            acc = acc >> 8;
            total -= 8;
            k++;
        end
        if (taken >= block_len) begin
            // close the block: flush the partial byte, mark the last one,
            // or send an empty closing result
            if (total > 0) begin
                partial = acc[7:0] & BYTE_W'((1 << total) - 1);
                block_sum = block_sum + SUM_W'(partial);
                grp[k] = '{partial, 1'b1, block_sum, err, 1'b1};
                k++;
            end else if (k > 0) begin
                grp[k-1].is_last = 1'b1;
            end else begin
                grp[k] = '{8'd0, 1'b0, block_sum, err, 1'b1};
                k++;
            end
            pend_bits = '0;
            pend_fill = '0;
            taken     = 0;
            block_sum = '0;
        end else begin
            pend_bits = acc[PEND_W-1:0];
            pend_fill = FILL_W'(total);
        end
        for (int unsigned i = 0; i < k; i++)
            expected_bytes.push_back(grp[i]);
    endfunction

    // Present requests from the queue, predict at each accepted one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                pack_index(s_tdata[INDEX_W-1:0]);
                requests++;
            end
            if (index_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                s_tvalid <= 1'b1;
                s_tdata  <= 16'(index_q.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Check each accepted result against the oldest expected byte
    always @(posedge aclk) begin : monitor
        packed_result_t got;
        packed_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[7:0], m_tuser[0], m_tdata[23:8], m_tuser[1], m_tlast};
                if (expected_bytes.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("unexpected result: byte %02h valid %0b sum %04h err %0b last %0b",
                                 got.data_byte, got.byte_valid, got.checksum,
                                 got.range_error, got.is_last);
                end else begin
                    want = expected_bytes.pop_front();
                    results++;
                    if (got.is_last)
                        block_ends++;
                    if (got.range_error)
                        flagged++;
                    if (got !== want) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"mismatch on result %0d: expected byte %02h valid %0b ",
                                      "sum %04h err %0b last %0b, got byte %02h valid %0b ",
                                      "sum %04h err %0b last %0b"},
                                     results, want.data_byte, want.byte_valid,
                                     want.checksum, want.range_error, want.is_last,
                                     got.data_byte, got.byte_valid, got.checksum,
                                     got.range_error, got.is_last);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Bound the run
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_bytes.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Hold until every queued request is taken and every result has come;
    // sample on the falling edge so the driver's updates have settled
    task automatic wait_idle();
        while (index_q.size() != 0 || s_tvalid || expected_bytes.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write entry_count while the packer is idle and track its effective value
    task automatic set_count(input int unsigned value);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= COUNT_W'(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        block_len  = (value == 0) ? 1 : ((value > MAX_ENTRIES) ? MAX_ENTRIES : value);
        entry_bits = 0;
        while ((1 << entry_bits) < block_len)
            entry_bits++;
        settings++;
    endtask

    initial begin
        int unsigned count_choices [N_CHOICES] = '{1, 2, 2, 3, 4, 5, 7, 8, 9, 13, 16,
                                                   17, 33, 0, 256, 1000, 4095, 4096,
                                                   4097, 8191};
        int unsigned n;
        int unsigned queued;

        send_idle = LOW_IDLE_PCT;
        recv_idle = HIGH_IDLE_PCT;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // one entry per block at reset: empty closing results, one out of range
        index_q.push_back(12'd0);
        index_q.push_back(12'd4095);

        // zero count acts as one
        set_count(0);
        index_q.push_back(12'd1);

        // one bit per entry: two blocks with a partial byte each
        set_count(2);
        index_q.push_back(12'd1);
        index_q.push_back(12'd0);
        index_q.push_back(12'd1);
        index_q.push_back(12'd3);

        // eight bits per entry: one byte per request, block left open
        set_count(256);
        index_q.push_back(12'd255);
        index_q.push_back(12'd0);
        index_q.push_back(12'd256);
        index_q.push_back(12'd170);

        // shrink the count mid-block: next request ends it at once
        set_count(3);
        index_q.push_back(12'd2);

        // block that ends exactly on a byte boundary
        set_count(4);
        index_q.push_back(12'd3);
        index_q.push_back(12'd0);
        index_q.push_back(12'd2);
        index_q.push_back(12'd1);

        // counts above the maximum saturate to twelve-bit entries
        set_count(8191);
        index_q.push_back(12'd4095);
        index_q.push_back(12'hAAA);
        index_q.push_back(12'h555);
        set_count(4097);
        index_q.push_back(12'd0);

        // random phases: mostly whole blocks of in-range indexes, some noise
        queued = 0;
        while (queued < RANDOM_ITEMS) begin
            if (queued >= 2 * RANDOM_ITEMS / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end else if (queued >= RANDOM_ITEMS / 3) begin
                send_idle = HIGH_IDLE_PCT;
                recv_idle = LOW_IDLE_PCT;
            end
            set_count(count_choices[$urandom_range(0, N_CHOICES - 1)]);
            if (block_len <= 40)
                n = block_len * $urandom_range(1, 3);
            else
                n = $urandom_range(4, 24);
            if ($urandom_range(0, 3) == 0)
                n += $urandom_range(1, 3);
            for (int unsigned i = 0; i < n; i++) begin
                if ($urandom_range(0, 99) < IN_RANGE_PCT)
                    index_q.push_back(INDEX_W'($urandom_range(0, block_len - 1)));
                else
                    index_q.push_back(INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1)));
            end
            queued += n;
        end

        wait_idle();
        errors += expected_bytes.size();
        $display("Ran %0d index requests under %0d entry_count writes in %0d cycles.",
                 requests, settings, cycles);
        $display("Checked %0d packed results: %0d block ends, %0d flagged out of range.",
                 results, block_ends, flagged);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
